@@ src/bbc_pkg.sv @@
// bbc_pkg: shared types and constants of the balanced bracket checker.
// No dependencies; the front, queue and back modules reference it by scoped names.
`default_nettype none

package bbc_pkg;

	// work that the front hands to the back
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_END  = 2'd2
	} op_t;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_ROUND  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_CURLY  = 2'd2;

	typedef struct packed {
		op_t   op;
		kind_t kind;
	} token_t;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_BALANCED   = 2'd0;
	localparam status_t STATUS_UNBALANCED = 2'd1;
	localparam status_t STATUS_OVERFLOW   = 2'd2;

	localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

	// token queue; depth is a power of two so the pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

endpackage

`default_nettype wire

@@ src/bbc_ram.sv @@
// bbc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ src/bbc_front.sv @@
// bbc_front: input handshake and byte classification into stack tokens.
// Depends on bbc_pkg; feeds bbc_queue.
`default_nettype none

module bbc_front (
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        line_end,
	output logic             enq_valid,
	input  wire logic        enq_ready,
	output bbc_pkg::token_t  enq_data
);

	logic keep;

	always_comb begin
		keep          = 1'b1;
		enq_data.op   = bbc_pkg::OP_END;
		enq_data.kind = bbc_pkg::KIND_ROUND;
		if (line_end) begin
			enq_data.op = bbc_pkg::OP_END;
		end else begin
			unique case (text_byte)
				bbc_pkg::CHAR_OPEN_ROUND: begin
					enq_data.op   = bbc_pkg::OP_PUSH;
					enq_data.kind = bbc_pkg::KIND_ROUND;
				end
				bbc_pkg::CHAR_OPEN_SQUARE: begin
					enq_data.op   = bbc_pkg::OP_PUSH;
					enq_data.kind = bbc_pkg::KIND_SQUARE;
				end
				bbc_pkg::CHAR_OPEN_CURLY: begin
					enq_data.op   = bbc_pkg::OP_PUSH;
					enq_data.kind = bbc_pkg::KIND_CURLY;
				end
				bbc_pkg::CHAR_CLOSE_ROUND: begin
					enq_data.op   = bbc_pkg::OP_POP;
					enq_data.kind = bbc_pkg::KIND_ROUND;
				end
				bbc_pkg::CHAR_CLOSE_SQUARE: begin
					enq_data.op   = bbc_pkg::OP_POP;
					enq_data.kind = bbc_pkg::KIND_SQUARE;
				end
				bbc_pkg::CHAR_CLOSE_CURLY: begin
					enq_data.op   = bbc_pkg::OP_POP;
					enq_data.kind = bbc_pkg::KIND_CURLY;
				end
				// drop plain text: it never touches the stack
				default: keep = 1'b0;
			endcase
		end
	end

	assign in_ready  = enq_ready;
	assign enq_valid = in_valid && keep;

endmodule

`default_nettype wire

@@ src/bbc_queue.sv @@
// bbc_queue: short token FIFO between the front and the back.
// Depends on bbc_pkg.
`default_nettype none

module bbc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            enq_valid,
	output logic                 enq_ready,
	input  wire bbc_pkg::token_t enq_data,
	output logic                 deq_valid,
	input  wire logic            deq_ready,
	output bbc_pkg::token_t      deq_data
);

	localparam logic [bbc_pkg::QCNT_W-1:0] Full = bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH);

	bbc_pkg::token_t                 entry_q [bbc_pkg::QUEUE_DEPTH];
	logic [bbc_pkg::QPTR_W-1:0]      head_q;
	logic [bbc_pkg::QPTR_W-1:0]      tail_q;
	logic [bbc_pkg::QCNT_W-1:0]      count_q;
	logic                            do_enq;
	logic                            do_deq;

	assign enq_ready = (count_q != Full);
	assign deq_valid = (count_q != '0);
	assign deq_data  = entry_q[head_q];
	assign do_enq    = enq_valid && enq_ready;
	assign do_deq    = deq_valid && deq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_enq) begin
				tail_q <= tail_q + 1'b1;
			end
			if (do_deq) begin
				head_q <= head_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				count_q <= count_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			entry_q[tail_q] <= enq_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Full)
		else $error("token queue count beyond depth");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == Full) |-> (head_q == tail_q))
		else $error("token queue pointers disagree with count");

endmodule

`default_nettype wire

@@ src/bbc_back.sv @@
// bbc_back: bracket stack, per-line flags, line counter and result register.
// Depends on bbc_pkg and bbc_ram; takes tokens from bbc_queue.
`default_nettype none

module bbc_back #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            tok_valid,
	output logic                 tok_ready,
	input  wire bbc_pkg::token_t tok,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           line_status,
	output logic [15:0]          line_number
);

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [LW-1:0] LevelMax = LW'(STACK_DEPTH);
	localparam logic [LW-1:0] SecondOffset = LW'(2);

	logic [LW-1:0]       level_q, level_d;
	logic                mismatch_q, mismatch_d;
	logic                exceeded_q, exceeded_d;
	logic [15:0]         line_q;
	bbc_pkg::kind_t      top_q, top_d;
	bbc_pkg::kind_t      second;
	logic                take;
	logic                take_end;
	logic                ignore;
	logic                we;
	logic [LW-1:0]       rd_level;
	logic                out_valid_q;
	bbc_pkg::status_t    status_s2;
	logic [15:0]         number_s2;
	bbc_pkg::status_t    status;

	assign tok_ready = (tok.op != bbc_pkg::OP_END) || !out_valid_q || out_ready;
	assign take      = tok_valid && tok_ready;
	assign take_end  = take && (tok.op == bbc_pkg::OP_END);
	assign ignore    = mismatch_q || exceeded_q;

	always_comb begin
		level_d    = level_q;
		mismatch_d = mismatch_q;
		exceeded_d = exceeded_q;
		top_d      = top_q;
		we         = 1'b0;
		if (take) begin
			unique case (tok.op)
				bbc_pkg::OP_END: begin
					level_d    = '0;
					mismatch_d = 1'b0;
					exceeded_d = 1'b0;
				end
				bbc_pkg::OP_PUSH: begin
					if (!ignore) begin
						if (level_q == LevelMax) begin
							exceeded_d = 1'b1;
						end else begin
							we      = 1'b1;
							level_d = level_q + 1'b1;
							top_d   = tok.kind;
						end
					end
				end
				bbc_pkg::OP_POP: begin
					if (!ignore) begin
						if (level_q == '0 || top_q != tok.kind) begin
							mismatch_d = 1'b1;
						end else begin
							level_d = level_q - 1'b1;
							top_d   = second;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (exceeded_q) begin
			status = bbc_pkg::STATUS_OVERFLOW;
		end else if (mismatch_q || level_q != '0) begin
			status = bbc_pkg::STATUS_UNBALANCED;
		end else begin
			status = bbc_pkg::STATUS_BALANCED;
		end
	end

	// prefetch the entry below the top for the level of the next cycle
	assign rd_level = level_d - SecondOffset;

	bbc_ram #(
		.WIDTH(2),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(level_q[AW-1:0]),
		.wdata(tok.kind),
		.raddr(rd_level[AW-1:0]),
		.rdata(second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			mismatch_q  <= 1'b0;
			exceeded_q  <= 1'b0;
			line_q      <= 16'd1;
			out_valid_q <= 1'b0;
		end else begin
			level_q    <= level_d;
			mismatch_q <= mismatch_d;
			exceeded_q <= exceeded_d;
			if (take_end) begin
				line_q      <= line_q + 16'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (take_end) begin
			status_s2 <= status;
			number_s2 <= line_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_status = status_s2;
	assign line_number = number_s2;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LevelMax)
		else $error("stack level beyond depth");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		exceeded_q |-> (level_q == LevelMax))
		else $error("overflow flag without a full stack");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_end |=> (out_valid_q && level_q == '0 && !mismatch_q && !exceeded_q))
		else $error("terminator did not post a result and clear the line");

endmodule

`default_nettype wire

@@ src/balanced_bracket_checker.sv @@
// balanced_bracket_checker: per-line bracket balance checker, top level.
// Depends on bbc_pkg, bbc_front, bbc_queue, bbc_back (and bbc_ram below it).
//
// Usage:
//   Input channel (in_valid/in_ready): one text_byte per request; a request
//   with line_end set terminates the line and text_byte is then ignored.
//   Output channel (out_valid/out_ready): one request per terminator with
//   line_status (0 balanced, 1 unbalanced, 2 nesting deeper than the stack)
//   and line_number (starts at 1, 16-bit wrap).
//   Throughput: one input request per cycle unless results back up on
//   out_ready. The front classifies bytes straight into a four-entry
//   token queue; the back executes one push, pop or terminator per cycle,
//   with the top of stack in a register and the entry below it prefetched
//   from the stack RAM every cycle. Results: a terminator passes through
//   the token queue to the back, which registers its status and line number.
//   Stall: while a result waits on out_ready the back still executes pushes
//   and pops; only a second terminator waits, and the queue fills up and
//   drops in_ready after three more queued brackets or terminators.
//   Reset: arst_n clears the queue, the per-line state and out_valid and
//   sets the line counter to 1. The stack RAM needs no clearing.
`default_nettype none

module balanced_bracket_checker #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        line_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       line_status,
	output logic [15:0]      line_number
);

	logic            enq_valid;
	logic            enq_ready;
	bbc_pkg::token_t enq_data;
	logic            deq_valid;
	logic            deq_ready;
	bbc_pkg::token_t deq_data;

	bbc_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.text_byte(text_byte),
		.line_end (line_end),
		.enq_valid(enq_valid),
		.enq_ready(enq_ready),
		.enq_data (enq_data)
	);

	bbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq_valid(enq_valid),
		.enq_ready(enq_ready),
		.enq_data (enq_data),
		.deq_valid(deq_valid),
		.deq_ready(deq_ready),
		.deq_data (deq_data)
	);

	bbc_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (deq_valid),
		.tok_ready  (deq_ready),
		.tok        (deq_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_status(line_status),
		.line_number(line_number)
	);

endmodule

`default_nettype wire

@@ test/balanced_bracket_checker_tb.sv @@
// Self-checking testbench for balanced_bracket_checker: drives lines of text bytes and
// terminators, predicts each line outcome and compares every result in order.
// Depends on bbc_pkg and the balanced_bracket_checker RTL.
`timescale 1ns / 100ps

module balanced_bracket_checker_tb;

	localparam int STACK_DEPTH  = 64;
	localparam int QUIET_LIMIT  = 4000;
	localparam int IDLE_PERCENT = 31;
	localparam int ITEM_TARGET  = 550;

	typedef struct {
		bbc_pkg::status_t status;
		logic [15:0]      number;
	} line_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        line_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  line_status;
	logic [15:0] line_number;

	bit          idle_en = 1'b1;
	int          failures = 0;
	int          quiet_cycles = 0;
	int          items_sent = 0;
	int          lines_sent = 0;

	// predicted per-line state
	bbc_pkg::kind_t kind_stack [STACK_DEPTH];
	int             open_level = 0;
	bit             line_mismatch = 1'b0;
	bit             line_overflow = 1'b0;
	logic [15:0]    next_line_no = 16'd1;

	line_outcome_t pending_outcomes [$];

	balanced_bracket_checker #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.line_end   (line_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.line_status(line_status),
		.line_number(line_number)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic bit opens(input logic [7:0] b, output bbc_pkg::kind_t k);
		k = bbc_pkg::KIND_ROUND;
		case (b)
			bbc_pkg::CHAR_OPEN_ROUND:  return 1'b1;
			bbc_pkg::CHAR_OPEN_SQUARE: begin
				k = bbc_pkg::KIND_SQUARE;
				return 1'b1;
			end
			bbc_pkg::CHAR_OPEN_CURLY:  begin
				k = bbc_pkg::KIND_CURLY;
				return 1'b1;
			end
			default:                   return 1'b0;
		endcase
	endfunction

	function automatic bit closes(input logic [7:0] b, output bbc_pkg::kind_t k);
		k = bbc_pkg::KIND_ROUND;
		case (b)
			bbc_pkg::CHAR_CLOSE_ROUND:  return 1'b1;
			bbc_pkg::CHAR_CLOSE_SQUARE: begin
				k = bbc_pkg::KIND_SQUARE;
				return 1'b1;
			end
			bbc_pkg::CHAR_CLOSE_CURLY:  begin
				k = bbc_pkg::KIND_CURLY;
				return 1'b1;
			end
			default:                    return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] open_char(input bbc_pkg::kind_t k);
		case (k)
			bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_OPEN_SQUARE;
			bbc_pkg::KIND_CURLY:  return bbc_pkg::CHAR_OPEN_CURLY;
			default:              return bbc_pkg::CHAR_OPEN_ROUND;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input bbc_pkg::kind_t k);
		case (k)
			bbc_pkg::KIND_SQUARE: return bbc_pkg::CHAR_CLOSE_SQUARE;
			bbc_pkg::KIND_CURLY:  return bbc_pkg::CHAR_CLOSE_CURLY;
			default:              return bbc_pkg::CHAR_CLOSE_ROUND;
		endcase
	endfunction

	function automatic bbc_pkg::kind_t any_kind();
		return bbc_pkg::kind_t'($urandom_range(0, 2));
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0]     b;
		bbc_pkg::kind_t k;
		do
			b = 8'($urandom_range(0, 255));
		while (opens(b, k) || closes(b, k));
		return b;
	endfunction

	// advance the predicted line state by one accepted request
	task automatic track_brackets(input logic [7:0] b, input logic e);
		bbc_pkg::kind_t k;
		line_outcome_t  res;
		if (e) begin
			if (line_overflow)
				res.status = bbc_pkg::STATUS_OVERFLOW;
			else if (line_mismatch || open_level != 0)
				res.status = bbc_pkg::STATUS_UNBALANCED;
			else
				res.status = bbc_pkg::STATUS_BALANCED;
			res.number = next_line_no;
			pending_outcomes.insert(pending_outcomes.size(), res);
			next_line_no  = next_line_no + 16'd1;
			open_level    = 0;
			line_mismatch = 1'b0;
			line_overflow = 1'b0;
		end else if (!line_mismatch && !line_overflow) begin
			if (opens(b, k)) begin
				if (open_level == STACK_DEPTH) begin
					line_overflow = 1'b1;
				end else begin
					kind_stack[open_level] = k;
					open_level++;
				end
			end else if (closes(b, k)) begin
				if (open_level == 0 || kind_stack[open_level - 1] != k)
					line_mismatch = 1'b1;
				else
					open_level--;
			end
		end
	endtask

	task automatic send_item(input logic [7:0] b, input logic e);
		in_valid  <= 1'b1;
		text_byte <= b;
		line_end  <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_brackets(b, e);
		items_sent++;
		if (e)
			lines_sent++;
		while (idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic test_basic_lines();
		send_line("");
		send_line("()[]{}");
		send_line("([{x}])");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h7F, 1'b0);
		// brackets on a terminator carry no meaning
		send_item(bbc_pkg::CHAR_OPEN_ROUND, 1'b1);
		send_item(bbc_pkg::CHAR_CLOSE_CURLY, 1'b1);
		send_line("((");
	endtask

	task automatic test_mismatched_close();
		send_line(")");
		send_line("(]()");
		send_line("{)");
		send_line("[}[[[");
		send_line("()]");
	endtask

	task automatic test_stack_overflow();
		bbc_pkg::kind_t opened [$];
		bbc_pkg::kind_t k;
		// fill to the last entry and unwind: balanced
		repeat (STACK_DEPTH) begin
			k = any_kind();
			opened.insert(opened.size(), k);
			send_item(open_char(k), 1'b0);
		end
		while (opened.size() != 0)
			send_item(close_char(opened.pop_back()), 1'b0);
		send_item(8'h00, 1'b1);
		// one push too many, then two closes that must be ignored
		repeat (STACK_DEPTH + 1) begin
			k = any_kind();
			opened.insert(opened.size(), k);
			send_item(open_char(k), 1'b0);
		end
		send_item(bbc_pkg::CHAR_CLOSE_ROUND, 1'b0);
		send_item(bbc_pkg::CHAR_CLOSE_SQUARE, 1'b0);
		send_item(8'hFF, 1'b1);
		opened.delete();
	endtask

	task automatic send_random_line();
		bbc_pkg::kind_t opened [$];
		bbc_pkg::kind_t k;
		int    shape;
		int    length;
		int    max_depth;
		int    r;
		bit    broken;
		shape  = $urandom_range(0, 99);
		length = $urandom_range(0, 14);
		broken = 1'b0;
		max_depth = $urandom_range(1, 8);
		if ($urandom_range(0, 29) == 0)
			max_depth = STACK_DEPTH - 1 + $urandom_range(0, 2);
		if (shape < 15) begin
			// noise: bracket-heavy random bytes
			repeat (length) begin
				r = $urandom_range(0, 3);
				if (r == 0)
					send_item(open_char(any_kind()), 1'b0);
				else if (r == 1)
					send_item(close_char(any_kind()), 1'b0);
				else
					send_item(8'($urandom_range(0, 255)), 1'b0);
			end
		end else begin
			if (max_depth > 8) begin
				repeat (max_depth) begin
					k = any_kind();
					opened.insert(opened.size(), k);
					send_item(open_char(k), 1'b0);
				end
			end
			repeat (length) begin
				r = $urandom_range(0, 99);
				if (r < 35 && opened.size() < max_depth) begin
					k = any_kind();
					opened.insert(opened.size(), k);
					send_item(open_char(k), 1'b0);
				end else if (r < 70 && shape < 30 && !broken && $urandom_range(0, 2) == 0) begin
					// wrong kind on top, or a close with nothing open
					broken = 1'b1;
					if (opened.size() == 0)
						k = any_kind();
					else
						k = bbc_pkg::kind_t'((int'(opened[$]) + 1 + $urandom_range(0, 1)) % 3);
					send_item(close_char(k), 1'b0);
				end else if (r < 70 && opened.size() != 0) begin
					send_item(close_char(opened.pop_back()), 1'b0);
				end else begin
					send_item(plain_char(), 1'b0);
				end
			end
			// leave the line open for one shape, else close everything
			if (shape >= 40 || shape < 30) begin
				while (opened.size() != 0)
					send_item(close_char(opened.pop_back()), 1'b0);
			end
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic test_random_text();
		int first_item;
		int first_line;
		first_item = items_sent;
		first_line = lines_sent;
		// hold both sides busy for a stretch
		idle_en <= 1'b0;
		while (items_sent < first_item + 200)
			send_random_line();
		idle_en <= 1'b1;
		while (items_sent < ITEM_TARGET || lines_sent < first_line + 40)
			send_random_line();
	endtask

	always @(posedge clk)
		out_ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PERCENT);

	always @(posedge clk) begin : check_result
		line_outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				$error("unexpected result: line_status %0d, line_number %0d",
					line_status, line_number);
				failures++;
			end else begin
				want = pending_outcomes.pop_front();
				if (line_status !== want.status) begin
					$error("line_status: expected %0d, got %0d", want.status, line_status);
					failures++;
				end
				if (line_number !== want.number) begin
					$error("line_number: expected %0d, got %0d", want.number, line_number);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_lines();
		test_mismatched_close();
		test_stack_overflow();
		test_random_text();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
